>>> rtl/sacts_pkg.sv
// Shared definitions for the set-associative cache tag store.
// Holds the configuration register layout, register indexes, reset values and defaults.
`timescale 1ns / 1ps
package sacts_pkg;

	localparam int DEF_MAX_SETS      = 64;
	localparam int DEF_MAX_WAYS      = 8;
	localparam int DEF_ADDRESS_WIDTH = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int SB_W       = 3;
	localparam int OB_W       = 4;
	localparam int WIU_W      = 4;
	localparam int WAY_OUT_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 2'd3;

	localparam logic [SB_W-1:0]  RST_SET_BITS    = 3'd2;
	localparam logic [OB_W-1:0]  RST_OFFSET_BITS = 4'd3;
	localparam logic [WIU_W-1:0] RST_WAYS_IN_USE = 4'd2;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic [OB_W-1:0] OB_MAX = 4'd8;

	typedef struct packed {
		logic [SB_W-1:0]  set_bits;
		logic [OB_W-1:0]  offset_bits;
		logic [WIU_W-1:0] ways_in_use;
		logic             policy_mode;
	} cfg_t;

endpackage

>>> rtl/set_assoc_cache_tag_store_core.sv
// Top level of the set-associative cache tag store: configuration registers,
// front end, queue and back end. Depends on sacts_pkg, sacts_front, sacts_queue, sacts_back.
`timescale 1ns / 1ps
// One address beat in, one result beat out, in order. Sustained rate is one beat
// per cycle while out_ready stays high; an accepted address passes the queue, the
// stage-1 registers and the output register. Each access does a read-modify-write
// of one set row of the tag store (tags, valid bits, recency ranks, FIFO pointer),
// read on issue and written back when its result is registered; back-to-back
// accesses to the same set are forwarded around the memory. Every set starts
// invalid through a per-set flag cleared by reset, so no clearing pass is needed
// after reset. Configuration may be changed only while no access is in flight.
module set_assoc_cache_tag_store_core #(
	parameter int MAX_SETS      = sacts_pkg::DEF_MAX_SETS,
	parameter int MAX_WAYS      = sacts_pkg::DEF_MAX_WAYS,
	parameter int ADDRESS_WIDTH = sacts_pkg::DEF_ADDRESS_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [sacts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sacts_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ADDRESS_WIDTH-1:0]             access_address,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic [sacts_pkg::WAY_OUT_W-1:0]      way_index,
	output logic                                 evicted_valid
);
	import sacts_pkg::*;

	localparam int SET_W = $clog2(MAX_SETS + 1) - 1;
	localparam int TAG_W = ADDRESS_WIDTH - 2;
	localparam int Q_W   = SET_W + TAG_W;

	cfg_t             cfg_q;
	logic             push_valid;
	logic             push_ready;
	logic [SET_W-1:0] push_set;
	logic [TAG_W-1:0] push_tag;
	logic             pop_valid;
	logic             pop_ready;
	logic [Q_W-1:0]   pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits    <= RST_SET_BITS;
			cfg_q.offset_bits <= RST_OFFSET_BITS;
			cfg_q.ways_in_use <= RST_WAYS_IN_USE;
			cfg_q.policy_mode <= POLICY_FIFO;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SET_BITS: begin
					cfg_q.set_bits <= cfg_wdata[SB_W-1:0];
				end
				REG_OFFSET_BITS: begin
					cfg_q.offset_bits <= cfg_wdata[OB_W-1:0];
				end
				REG_WAYS_IN_USE: begin
					cfg_q.ways_in_use <= cfg_wdata[WIU_W-1:0];
				end
				REG_POLICY_MODE: begin
					cfg_q.policy_mode <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	sacts_front #(
		.ADDRESS_WIDTH (ADDRESS_WIDTH),
		.MAX_SETS      (MAX_SETS)
	) u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.access_address (access_address),
		.cfg            (cfg_q),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_set       (push_set),
		.push_tag       (push_tag)
	);

	sacts_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_set, push_tag}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sacts_back #(
		.ADDRESS_WIDTH (ADDRESS_WIDTH),
		.MAX_SETS      (MAX_SETS),
		.MAX_WAYS      (MAX_WAYS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_set       (pop_data[Q_W-1:TAG_W]),
		.pop_tag       (pop_data[TAG_W-1:0]),
		.cfg           (cfg_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.way_index     (way_index),
		.evicted_valid (evicted_valid)
	);

endmodule

>>> rtl/sacts_front.sv
// Front end: takes address beats and splits them into set index and tag.
// Uses sacts_pkg for the configuration layout; feeds sacts_queue.
`timescale 1ns / 1ps
module sacts_front #(
	parameter int ADDRESS_WIDTH = 32,
	parameter int MAX_SETS      = 64
) (
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic [ADDRESS_WIDTH-1:0]                     access_address,
	input  sacts_pkg::cfg_t                              cfg,
	output logic                                         push_valid,
	input  logic                                         push_ready,
	output logic [$clog2(MAX_SETS+1)-2:0]                push_set,
	output logic [ADDRESS_WIDTH-3:0]                     push_tag
);
	import sacts_pkg::*;

	localparam int SET_W = $clog2(MAX_SETS + 1) - 1;
	localparam int TAG_W = ADDRESS_WIDTH - 2;
	localparam int SH_W  = OB_W + 1;
	localparam logic [SB_W-1:0] SB_LIM = SB_W'((SET_W > 7) ? 7 : SET_W);

	logic [SB_W-1:0]          sb;
	logic [OB_W-1:0]          ob;
	logic [SH_W-1:0]          tag_sh;
	logic [SET_W-1:0]         set_mask;
	logic [ADDRESS_WIDTH-1:0] off_sh;
	logic [ADDRESS_WIDTH-1:0] tag_full;

	always_comb begin
		sb = cfg.set_bits;
		if (sb == '0) begin
			sb = SB_W'(1);
		end
		if (sb > SB_LIM) begin
			sb = SB_LIM;
		end
		ob = cfg.offset_bits;
		if (ob == '0) begin
			ob = OB_W'(1);
		end
		if (ob > OB_MAX) begin
			ob = OB_MAX;
		end
		off_sh   = access_address >> ob;
		set_mask = ~({SET_W{1'b1}} << sb);
		tag_sh   = SH_W'(ob) + SH_W'(sb);
		tag_full = access_address >> tag_sh;
	end

	assign push_set   = off_sh[SET_W-1:0] & set_mask;
	assign push_tag   = tag_full[TAG_W-1:0];
	assign push_valid = in_valid;
	assign in_ready   = push_ready;

endmodule

>>> rtl/sacts_queue.sv
// Two-entry queue between the front end and the lookup/update back end.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
module sacts_queue #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] slot_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = slot_q[rp_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_fire) begin
				wp_q <= ~wp_q;
			end
			if (pop_fire) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push_fire) - 2'(pop_fire);
		end
	end

endmodule

>>> rtl/sacts_back.sv
// Back end: per-set row read, hit/victim selection, recency update and write-back.
// Uses sacts_pkg; holds the tag store memory and the output register.
`timescale 1ns / 1ps
module sacts_back #(
	parameter int ADDRESS_WIDTH = 32,
	parameter int MAX_SETS      = 64,
	parameter int MAX_WAYS      = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  logic [$clog2(MAX_SETS+1)-2:0]        pop_set,
	input  logic [ADDRESS_WIDTH-3:0]             pop_tag,
	input  sacts_pkg::cfg_t                      cfg,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic [sacts_pkg::WAY_OUT_W-1:0]      way_index,
	output logic                                 evicted_valid
);
	import sacts_pkg::*;

	localparam int SET_W  = $clog2(MAX_SETS + 1) - 1;
	localparam int NSETS  = 2 ** SET_W;
	localparam int TAG_W  = ADDRESS_WIDTH - 2;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int CNT_W  = $clog2(MAX_WAYS + 1);
	localparam int NW_W   = (CNT_W > WIU_W) ? CNT_W : WIU_W;
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
	localparam logic [NW_W-1:0]   NW_MAX   = NW_W'(MAX_WAYS);

	typedef struct packed {
		logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
		logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
		logic [MAX_WAYS-1:0]             valid;
		logic [WAY_W-1:0]                fptr;
	} row_t;

	row_t mem [NSETS];

	logic             row_ok_q [NSETS];
	logic             v_s1;
	logic             ok_s1;
	logic             byp_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	row_t             rd_s1;
	row_t             byp_row_s1;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic                 evict_q;

	logic                 issue;
	logic                 done;
	logic                 same_set;
	row_t                 cur;
	row_t                 nxt;
	logic [NW_W-1:0]      n;
	logic [MAX_WAYS-1:0]  en;
	logic                 any_hit;
	logic                 any_inv;
	logic [WAY_W-1:0]     hit_w;
	logic [WAY_W-1:0]     inv_w;
	logic [WAY_W-1:0]     lru_w;
	logic [WAY_W-1:0]     fp;
	logic [WAY_W-1:0]     fp_nx;
	logic [NW_W-1:0]      fp_inc;
	logic [WAY_W-1:0]     w;
	logic                 fresh;
	logic [RANK_W-1:0]    old_rank;

	assign done      = v_s1 && (!out_valid_q || out_ready);
	assign issue     = pop_valid && (!v_s1 || done);
	assign pop_ready = issue;
	assign same_set  = done && (pop_set == set_s1);

	always_comb begin
		cur = byp_s1 ? byp_row_s1 : rd_s1;
		if (!ok_s1) begin
			cur.valid = '0;
			cur.rank  = '0;
			cur.fptr  = '0;
		end

		n = NW_W'(cfg.ways_in_use);
		if (n == '0) begin
			n = NW_W'(1);
		end
		if (n > NW_MAX) begin
			n = NW_MAX;
		end

		any_hit = 1'b0;
		any_inv = 1'b0;
		hit_w   = '0;
		inv_w   = '0;
		for (int k = MAX_WAYS - 1; k >= 0; k--) begin
			en[k] = (NW_W'(k) < n);
			if (en[k] && cur.valid[k] && (cur.tag[k] == tag_s1)) begin
				any_hit = 1'b1;
				hit_w   = WAY_W'(k);
			end
			if (en[k] && !cur.valid[k]) begin
				any_inv = 1'b1;
				inv_w   = WAY_W'(k);
			end
		end

		lru_w = '0;
		for (int k = 1; k < MAX_WAYS; k++) begin
			if (en[k] && (cur.rank[k] > cur.rank[lru_w])) begin
				lru_w = WAY_W'(k);
			end
		end

		fp = cur.fptr;
		if (NW_W'(fp) >= n) begin
			fp = '0;
		end
		fp_inc = NW_W'(fp) + NW_W'(1);
		fp_nx  = (fp_inc >= n) ? '0 : WAY_W'(fp_inc);

		nxt   = cur;
		fresh = 1'b0;
		if (any_hit) begin
			w = hit_w;
		end else if (any_inv) begin
			w     = inv_w;
			fresh = 1'b1;
		end else if (cfg.policy_mode == POLICY_LRU) begin
			w = lru_w;
		end else begin
			w        = fp;
			nxt.fptr = fp_nx;
		end

		old_rank = cur.rank[w];
		for (int k = 0; k < MAX_WAYS; k++) begin
			if ((k != int'(w)) && en[k] && cur.valid[k]
					&& (fresh || (cur.rank[k] < old_rank))
					&& (cur.rank[k] < RANK_MAX)) begin
				nxt.rank[k] = cur.rank[k] + RANK_W'(1);
			end
		end
		nxt.rank[w]  = '0;
		nxt.valid[w] = 1'b1;
		nxt.tag[w]   = tag_s1;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= mem[pop_set];
		end
		if (done) begin
			mem[set_s1] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			set_s1     <= pop_set;
			tag_s1     <= pop_tag;
			byp_row_s1 <= nxt;
		end
		if (done) begin
			hit_q   <= any_hit;
			way_q   <= WAY_OUT_W'(w);
			evict_q <= !any_hit && !any_inv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			ok_s1       <= 1'b0;
			byp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NSETS; i++) begin
				row_ok_q[i] <= 1'b0;
			end
		end else begin
			if (issue) begin
				v_s1   <= 1'b1;
				byp_s1 <= same_set;
				ok_s1  <= row_ok_q[pop_set] || same_set;
			end else if (done) begin
				v_s1 <= 1'b0;
			end
			if (done) begin
				row_ok_q[set_s1] <= 1'b1;
				out_valid_q      <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign way_index     = way_q;
	assign evicted_valid = evict_q;

endmodule

>>> verif/tb_set_assoc_cache_tag_store_core.sv
// Testbench for set_assoc_cache_tag_store_core: drives address beats, predicts hit/way/evict
// with a behavioral tag store (FIFO and LRU), checks results in order. Depends on sacts_pkg
// and the core RTL.
`timescale 1ns / 1ps
module tb_set_assoc_cache_tag_store_core;
	import sacts_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SB_LIMIT    = $clog2(DEF_MAX_SETS);

	typedef struct {
		logic [31:0] addr;
		logic        hit;
		logic [2:0]  way;
		logic        evicted;
	} lookup_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [31:0]           access_address;
	logic                  out_valid;
	logic                  out_ready;
	logic                  hit;
	logic [WAY_OUT_W-1:0]  way_index;
	logic                  evicted_valid;

	// behavioral tag store
	bit          line_ok  [DEF_MAX_SETS][DEF_MAX_WAYS];
	logic [31:0] line_tag [DEF_MAX_SETS][DEF_MAX_WAYS];
	int          age_rank [DEF_MAX_SETS][DEF_MAX_WAYS];
	int          rr_ptr   [DEF_MAX_SETS];
	logic [SB_W-1:0]  set_bits_q;
	logic [OB_W-1:0]  offset_bits_q;
	logic [WIU_W-1:0] ways_q;
	logic             policy_q;

	lookup_t     pending_lookups[$];
	int          mismatches  = 0;
	int          cycles      = 0;
	int          sink_hold   = 0;
	bit          src_idle_on = 1'b1;
	bit          sink_idle_on = 1'b1;
	logic [31:0] tag_salt    = '0;

	set_assoc_cache_tag_store_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.access_address (access_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.way_index      (way_index),
		.evicted_valid  (evicted_valid)
	);

	always #10 clk = ~clk;

	function automatic void effective_geometry(output int sb, output int ob, output int ways);
		sb   = (set_bits_q == 0) ? 1 : ((set_bits_q > SB_LIMIT) ? SB_LIMIT : int'(set_bits_q));
		ob   = (offset_bits_q == 0) ? 1 : ((offset_bits_q > OB_MAX) ? OB_MAX : int'(offset_bits_q));
		ways = (ways_q == 0) ? 1 : ((ways_q > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(ways_q));
	endfunction

	function automatic void age_ranks(input int s, input int w, input int ways, input bit fresh);
		int k;
		int old;
		old = age_rank[s][w];
		for (k = 0; k < ways; k++)
			if (k != w && line_ok[s][k] && (fresh || age_rank[s][k] < old)
			    && age_rank[s][k] < DEF_MAX_WAYS - 1)
				age_rank[s][k]++;
		age_rank[s][w] = 0;
	endfunction

	function automatic lookup_t predict_lookup(input logic [31:0] addr);
		int sb, ob, ways, s, w, victim;
		logic [31:0] tag;
		lookup_t r;
		effective_geometry(sb, ob, ways);
		s         = int'((addr >> ob) & ((32'd1 << sb) - 1));
		tag       = addr >> (ob + sb);
		r.addr    = addr;
		r.hit     = 1'b0;
		r.way     = '0;
		r.evicted = 1'b0;
		for (w = 0; w < ways; w++)
			if (line_ok[s][w] && line_tag[s][w] == tag) begin
				age_ranks(s, w, ways, 1'b0);
				r.hit = 1'b1;
				r.way = 3'(w);
				return r;
			end
		victim = ways;
		for (w = ways - 1; w >= 0; w--)
			if (!line_ok[s][w])
				victim = w;
		if (victim < ways) begin
			age_ranks(s, victim, ways, 1'b1);
		end else begin
			r.evicted = 1'b1;
			if (policy_q == POLICY_LRU) begin
				victim = 0;
				for (w = 1; w < ways; w++)
					if (age_rank[s][w] > age_rank[s][victim])
						victim = w;
			end else begin
				victim = (rr_ptr[s] >= ways) ? 0 : rr_ptr[s];
				rr_ptr[s] = (victim + 1 >= ways) ? 0 : victim + 1;
			end
			age_ranks(s, victim, ways, 1'b0);
		end
		line_ok[s][victim]  = 1'b1;
		line_tag[s][victim] = tag;
		r.way = 3'(victim);
		return r;
	endfunction

	// mostly conflicting tags within sets 0..set_span, some fully random addresses
	function automatic logic [31:0] pick_address(input int set_span);
		int sb, ob, ways;
		logic [31:0] t, s, off;
		effective_geometry(sb, ob, ways);
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		t   = tag_salt ^ 32'($urandom_range(0, ways + 2));
		s   = 32'($urandom_range(0, set_span)) & ((32'd1 << sb) - 1);
		off = $urandom() & ((32'd1 << ob) - 1);
		return (t << (ob + sb)) | (s << ob) | off;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want_v,
	                               input logic [31:0] addr);
		$display("MISMATCH %s: got %0d, want %0d (address %h) at cycle %0d",
		         field, got, want_v, addr, cycles);
		mismatches++;
	endtask

	task automatic send_access(input logic [31:0] addr);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		access_address <= addr;
		do @(posedge clk); while (!in_ready);
		pending_lookups.push_back(predict_lookup(addr));
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_SET_BITS:    set_bits_q    = val[SB_W-1:0];
			REG_OFFSET_BITS: offset_bits_q = val[OB_W-1:0];
			REG_WAYS_IN_USE: ways_q        = val[WIU_W-1:0];
			REG_POLICY_MODE: policy_q      = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [3:0] sb, input logic [3:0] ob, input logic [3:0] ways,
	                         input logic [3:0] pol);
		quiesce();
		write_reg(REG_SET_BITS, sb);
		write_reg(REG_OFFSET_BITS, ob);
		write_reg(REG_WAYS_IN_USE, ways);
		write_reg(REG_POLICY_MODE, pol);
		cfg_wr_en <= 1'b0;
	endtask

	// reset geometry: set = addr[4:3], tag = addr[31:5], two ways, FIFO
	task automatic test_reset_defaults();
		send_access(32'h0000_0000);
		send_access(32'h0000_0007);
		send_access(32'hFFFF_FFFF);
		send_access(32'h0000_0020);
		send_access(32'h0000_0040);
		send_access(32'h0000_0005);
		send_access(32'h0000_0027);
		send_access(32'hFFFF_FFF8);
	endtask

	task automatic test_register_extremes();
		configure(4'h0, 4'h0, 4'h0, {3'b0, POLICY_FIFO});
		send_access(32'h0000_0000);
		send_access(32'h0000_0001);
		send_access(32'h0000_0004);
		configure(4'hF, 4'hF, 4'hF, 4'hF);
		send_access(32'hFFFF_FFFF);
		send_access(32'h0000_0000);
		send_access(32'h8000_0000);
	endtask

	// access twelve distinct sets once each, then shrink the set bits and ways before one more access
	task automatic test_fifo_pointer_wrap();
		int i;
		configure(4'h8, 4'h9, 4'h8, {3'b0, POLICY_FIFO});
		for (i = 0; i < 12; i++)
			send_access((32'(i + 16) << 9) | 32'h100);
		configure(4'h1, 4'h8, 4'h3, {3'b0, POLICY_FIFO});
		send_access((32'd30 << 9) | 32'h100);
	endtask

	task automatic test_random_phases();
		int p, i, set_span;
		for (p = 0; p < 12; p++) begin
			case (p)
				0: configure(4'h1, 4'h1, 4'h1, {3'b0, POLICY_FIFO});
				1: configure(4'h6, 4'h8, 4'h8, {3'b0, POLICY_LRU});
				2: configure(4'h7, 4'h0, 4'h9, {3'b0, POLICY_LRU});
				3: configure(4'h0, 4'hF, 4'h0, {3'b0, POLICY_FIFO});
				default: configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			endcase
			src_idle_on  = (p % 4 != 3);
			sink_idle_on = (p % 4 != 2);
			tag_salt     = $urandom_range(0, 1) ? $urandom() : '0;
			set_span     = $urandom_range(0, 1) ? 3 : 63;
			for (i = 0; i < 140; i++)
				send_access(pick_address(set_span));
		end
	endtask

	task automatic test_receiver_stall();
		int i;
		configure(4'h2, 4'h3, 4'h4, {3'b0, POLICY_LRU});
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		sink_hold    = 250;
		for (i = 0; i < 60; i++)
			send_access(pick_address(3));
	endtask

	task automatic test_full_rate();
		int i;
		configure(4'h3, 4'h2, 4'h4, {3'b0, POLICY_FIFO});
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		for (i = 0; i < 150; i++)
			send_access(pick_address(7));
	endtask

	// result sink readiness: random stalls plus one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lookups.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0, '0);
			end else begin
				want = pending_lookups.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", hit, want.hit, want.addr);
				if (way_index !== want.way)
					report_mismatch("way_index", way_index, want.way, want.addr);
				if (evicted_valid !== want.evicted)
					report_mismatch("evicted_valid", evicted_valid, want.evicted, want.addr);
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_index      <= REG_SET_BITS;
		cfg_wdata      <= '0;
		in_valid       <= 1'b0;
		access_address <= '0;
		set_bits_q    = RST_SET_BITS;
		offset_bits_q = RST_OFFSET_BITS;
		ways_q        = RST_WAYS_IN_USE;
		policy_q      = POLICY_FIFO;
		foreach (line_ok[s, w]) begin
			line_ok[s][w]  = 1'b0;
			line_tag[s][w] = '0;
			age_rank[s][w] = 0;
		end
		foreach (rr_ptr[s])
			rr_ptr[s] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_fifo_pointer_wrap();
		test_random_phases();
		test_receiver_stall();
		test_full_rate();
		quiesce();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
